/* hdl/icmp_echo_header_generator_core_assert.svh */
`ifndef ICMP_ECHO_HEADER_GENERATOR_CORE_ASSERT_SVH
`define ICMP_ECHO_HEADER_GENERATOR_CORE_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define IEH_ASSERT_NOW(label, clk, rst_n, cond, conseq) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
		else $error("ICMP header assertion failed");

// Next-cycle implication, checked while out of reset.
`define IEH_ASSERT_NEXT(label, clk, rst_n, cond, conseq) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
		else $error("ICMP header assertion failed");

`endif

/* hdl/ieh_pkg.sv */
`timescale 1ns / 1ps

package ieh_pkg;

	localparam logic [7:0] TYPE_ECHO_REQUEST = 8'd8;
	localparam logic [7:0] TYPE_ECHO_REPLY = 8'd0;
	localparam logic [7:0] CODE_ECHO = 8'd0;
	localparam logic [15:0] SEQ_RESET = 16'd1;
	localparam logic [15:0] ID_RESET = 16'd0;

	// One input request as seen by the accumulator, with the header fields for it.
	typedef struct packed {
		logic fire;
		logic byte_valid;
		logic last;
		logic [7:0] payload_byte;
		logic [7:0] msg_type;
		logic [15:0] identifier;
		logic [15:0] seq_num;
	} ieh_item_t;

	// Finished payload sum and header fields, handed to the output stage.
	typedef struct packed {
		logic valid;
		logic [15:0] payload_sum;
		logic [7:0] msg_type;
		logic [15:0] identifier;
		logic [15:0] seq_num;
	} ieh_final_t;

	function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] t;
		t = {1'b0, a} + {1'b0, b};
		return t[15:0] + {15'd0, t[16]};
	endfunction

endpackage

/* hdl/icmp_echo_header_generator_core.sv */
`timescale 1ns / 1ps

// Builds an ICMP echo header from a stream of payload bytes and accepts one request per clock
// while not stalled. Each request is registered, its byte is then folded into a ones'
// complement running sum, and on the last request the sum and header fields are registered,
// then the header words are added and the header is registered on the result port. The result
// sits in an output register, so input flows on while a single header waits. Sequence numbers
// start at 1 after reset and advance by one per header. The user must write the identifier
// through cfg_we and cfg_wdata only while no packet is in flight; the block does not check.

module icmp_echo_header_generator_core
	import ieh_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	// payload_byte [7:0], byte_valid [8], zero fill [15:9]
	input logic [15:0] s_axis_tdata,
	input logic s_axis_tlast,
	// message_kind [0]
	input logic [0:0] s_axis_tuser,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// msg_type [7:0], msg_code [15:8], header_checksum [31:16],
	// header_identifier [47:32], header_sequence [63:48]
	output logic [63:0] m_axis_tdata,
	input logic cfg_we,
	input logic [15:0] cfg_wdata
);

	logic valid_s1;
	logic [7:0] byte_s1;
	logic byte_valid_s1;
	logic last_s1;
	logic kind_s1;
	logic [15:0] identifier_q;
	logic [15:0] next_seq_q;
	logic acc_ready;
	logic item_fire;
	ieh_item_t item;
	ieh_final_t fin;
	logic fin_ready;

	assign s_axis_tready = !valid_s1 || acc_ready;
	assign item_fire = valid_s1 && acc_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			identifier_q <= ID_RESET;
			next_seq_q <= SEQ_RESET;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (cfg_we) begin
				identifier_q <= cfg_wdata;
			end
			if (item_fire && last_s1) begin
				next_seq_q <= next_seq_q + 16'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata[7:0];
			byte_valid_s1 <= s_axis_tdata[8];
			last_s1 <= s_axis_tlast;
			kind_s1 <= s_axis_tuser[0];
		end
	end

	always_comb begin
		item.fire = item_fire;
		item.byte_valid = byte_valid_s1;
		item.last = last_s1;
		item.payload_byte = byte_s1;
		item.msg_type = kind_s1 ? TYPE_ECHO_REPLY : TYPE_ECHO_REQUEST;
		item.identifier = identifier_q;
		item.seq_num = next_seq_q;
	end

	ieh_accum u_accum (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.ready(acc_ready),
		.fin(fin),
		.fin_ready(fin_ready)
	);

	ieh_hdr_out u_hdr_out (
		.clk(clk),
		.arst_n(arst_n),
		.fin(fin),
		.fin_ready(fin_ready),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_data(m_axis_tdata)
	);

endmodule

/* hdl/ieh_accum.sv */
`timescale 1ns / 1ps

module ieh_accum
	import ieh_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input ieh_item_t item,
	output logic ready,
	output ieh_final_t fin,
	input logic fin_ready
);

	logic [15:0] running_sum_q;
	logic odd_q;
	logic [7:0] held_q;
	logic fin_valid_s2;
	logic [15:0] payload_sum_s2;
	logic [7:0] msg_type_s2;
	logic [15:0] identifier_s2;
	logic [15:0] seq_num_s2;
	logic [7:0] byte_eff;
	logic [15:0] add_word;
	logic [15:0] sum_next;

	// The word to add is the completed pair, or the zero-padded byte on the last request.
	always_comb begin
		byte_eff = item.byte_valid ? item.payload_byte : 8'd0;
		add_word = odd_q ? {held_q, byte_eff} : {byte_eff, 8'd0};
		sum_next = oc_add(running_sum_q, add_word);
	end

	assign ready = !fin_valid_s2 || fin_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_sum_q <= 16'd0;
			odd_q <= 1'b0;
			held_q <= 8'd0;
			fin_valid_s2 <= 1'b0;
		end else begin
			if (item.fire && item.last) begin
				running_sum_q <= 16'd0;
				odd_q <= 1'b0;
				held_q <= 8'd0;
			end else if (item.fire && item.byte_valid) begin
				if (odd_q) begin
					running_sum_q <= sum_next;
					odd_q <= 1'b0;
				end else begin
					held_q <= item.payload_byte;
					odd_q <= 1'b1;
				end
			end
			if (item.fire && item.last) begin
				fin_valid_s2 <= 1'b1;
			end else if (fin_ready) begin
				fin_valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item.fire && item.last) begin
			payload_sum_s2 <= sum_next;
			msg_type_s2 <= item.msg_type;
			identifier_s2 <= item.identifier;
			seq_num_s2 <= item.seq_num;
		end
	end

	assign fin = '{valid: fin_valid_s2, payload_sum: payload_sum_s2, msg_type: msg_type_s2,
		identifier: identifier_s2, seq_num: seq_num_s2};

endmodule

/* hdl/ieh_hdr_out.sv */
`timescale 1ns / 1ps

module ieh_hdr_out
	import ieh_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input ieh_final_t fin,
	output logic fin_ready,
	output logic out_valid,
	input logic out_ready,
	output logic [63:0] out_data
);

	logic out_valid_q;
	logic [63:0] out_data_q;
	logic [17:0] total;
	logic [16:0] fold1;
	logic [15:0] folded;

	// Four-term ones' complement sum, folded twice.
	always_comb begin
		total = {2'd0, fin.payload_sum} + {2'd0, fin.msg_type, 8'd0}
			+ {2'd0, fin.identifier} + {2'd0, fin.seq_num};
		fold1 = {1'b0, total[15:0]} + {15'd0, total[17:16]};
		folded = fold1[15:0] + {15'd0, fold1[16]};
	end

	assign fin_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin.valid && fin_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin.valid && fin_ready) begin
			out_data_q <= {fin.seq_num, fin.identifier, ~folded, CODE_ECHO, fin.msg_type};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

endmodule

/* hdl/ieh_checker.sv */
`timescale 1ns / 1ps

`include "icmp_echo_header_generator_core_assert.svh"

module ieh_checker
	import ieh_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [63:0] m_axis_tdata
);

	logic [15:0] prev_seq_q;
	logic out_fire;

	assign out_fire = m_axis_tvalid && m_axis_tready;

	// The first header after reset carries sequence 1, so the tracker starts one below it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_seq_q <= SEQ_RESET - 16'd1;
		end else if (out_fire) begin
			prev_seq_q <= m_axis_tdata[63:48];
		end
	end

	`IEH_ASSERT_NEXT(a_stall_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
	`IEH_ASSERT_NOW(a_code_zero, clk, arst_n, m_axis_tvalid, m_axis_tdata[15:8] == CODE_ECHO)
	`IEH_ASSERT_NOW(a_type_known, clk, arst_n, m_axis_tvalid, m_axis_tdata[7:0] == TYPE_ECHO_REQUEST || m_axis_tdata[7:0] == TYPE_ECHO_REPLY)
	`IEH_ASSERT_NOW(a_seq_step, clk, arst_n, out_fire, m_axis_tdata[63:48] == prev_seq_q + 16'd1)

endmodule

bind icmp_echo_header_generator_core ieh_checker u_ieh_checker (
	.clk(clk),
	.arst_n(arst_n),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata)
);

/* tb/sv/icmp_header_checker.sv */
`timescale 1ns / 1ps

module icmp_header_checker
	import ieh_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	// payload_byte [7:0], byte_valid [8], zero fill [15:9]
	input logic [15:0] s_axis_tdata,
	input logic s_axis_tlast,
	// message_kind [0]
	input logic [0:0] s_axis_tuser,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	// msg_type [7:0], msg_code [15:8], header_checksum [31:16],
	// header_identifier [47:32], header_sequence [63:48]
	input logic [63:0] m_axis_tdata,
	input logic cfg_we,
	input logic [15:0] cfg_wdata,
	output int mismatches,
	output int outstanding,
	output int headers_checked,
	output logic wrap_seen
);

	typedef struct {
		logic [7:0] msg_type;
		logic [7:0] msg_code;
		logic [15:0] checksum;
		logic [15:0] ident;
		logic [15:0] seq;
	} header_t;

	header_t header_q[$];
	logic [15:0] word_sum;
	logic odd_byte;
	logic [7:0] held_byte;
	logic [15:0] seq_next;
	logic [15:0] ident_reg;

	function automatic logic [15:0] end_around_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] t;
		t = {1'b0, a} + {1'b0, b};
		return t[15:0] + {15'd0, t[16]};
	endfunction

	task automatic report(input string msg);
		$display("%0t ns: %s", $time, msg);
		mismatches++;
	endtask

	task automatic check_field(input string field, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want)
			report($sformatf("header %0d %s: got 0x%h, expected 0x%h",
				headers_checked, field, got, want));
	endtask

	always @(posedge clk or negedge arst_n) begin
		header_t h;
		logic [15:0] total;
		if (!arst_n) begin
			header_q.delete();
			word_sum = '0;
			odd_byte = 1'b0;
			held_byte = '0;
			seq_next = SEQ_RESET;
			ident_reg = ID_RESET;
			mismatches = 0;
			outstanding = 0;
			headers_checked = 0;
			wrap_seen = 1'b0;
		end else begin
			if (cfg_we)
				ident_reg = cfg_wdata;

			if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tdata[8]) begin
					if (!odd_byte) begin
						held_byte = s_axis_tdata[7:0];
						odd_byte = 1'b1;
					end else begin
						word_sum = end_around_add(word_sum, {held_byte, s_axis_tdata[7:0]});
						odd_byte = 1'b0;
					end
				end
				if (s_axis_tlast) begin
					total = word_sum;
					if (odd_byte)
						total = end_around_add(total, {held_byte, 8'h00});
					h.msg_type = s_axis_tuser[0] ? TYPE_ECHO_REPLY : TYPE_ECHO_REQUEST;
					h.msg_code = CODE_ECHO;
					total = end_around_add(total, {h.msg_type, 8'h00});
					total = end_around_add(total, ident_reg);
					total = end_around_add(total, seq_next);
					h.checksum = ~total;
					h.ident = ident_reg;
					h.seq = seq_next;
					header_q.push_back(h);
					seq_next = seq_next + 16'd1;
					word_sum = '0;
					odd_byte = 1'b0;
					held_byte = '0;
				end
			end

			if (m_axis_tvalid && m_axis_tready) begin
				if (header_q.size() == 0) begin
					report($sformatf("header with nothing pending: 0x%h", m_axis_tdata));
				end else begin
					h = header_q.pop_front();
					check_field("type", {8'h00, m_axis_tdata[7:0]}, {8'h00, h.msg_type});
					check_field("code", {8'h00, m_axis_tdata[15:8]}, {8'h00, h.msg_code});
					check_field("checksum", m_axis_tdata[31:16], h.checksum);
					check_field("identifier", m_axis_tdata[47:32], h.ident);
					check_field("sequence", m_axis_tdata[63:48], h.seq);
					if (h.seq == 16'h0000)
						wrap_seen = 1'b1;
				end
				headers_checked++;
			end

			outstanding = header_q.size();
		end
	end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;
	import ieh_pkg::*;

	localparam logic KIND_REQUEST = 1'b0;
	localparam logic KIND_REPLY = 1'b1;
	localparam int IDLE_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 8;
	localparam int STEADY_PACKETS = 150;
	localparam int PHASE_REQUESTS = 210;

	typedef enum int {FILL_RANDOM, FILL_ONES, FILL_ZEROS, FILL_MIXED} fill_t;
	typedef enum int {SINK_OPEN, SINK_JITTER, SINK_STALLS} sink_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic s_axis_tlast = 1'b0;
	logic [0:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;
	logic cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;

	int mismatches;
	int outstanding;
	int headers_checked;
	logic wrap_seen;

	int requests_sent = 0;
	int id_writes = 0;
	int burst_left = 0;
	int idle_cycles = 0;
	bit steady = 1'b0;

	sink_mode_t sink_mode = SINK_OPEN;
	int sink_span = 0;
	int stall_left = 0;

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	icmp_echo_header_generator_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	icmp_header_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.mismatches(mismatches),
		.outstanding(outstanding),
		.headers_checked(headers_checked),
		.wrap_seen(wrap_seen)
	);

	// The header sink alternates between open, jittery and long-stall stretches.
	always @(negedge clk) begin
		if (sink_span == 0) begin
			sink_mode = sink_mode_t'($urandom_range(0, 2));
			sink_span = $urandom_range(40, 400);
		end
		sink_span--;
		if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else if (sink_mode == SINK_OPEN) begin
			m_axis_tready <= 1'b1;
		end else if (sink_mode == SINK_JITTER) begin
			m_axis_tready <= ($urandom_range(0, 9) < 6);
		end else if ($urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(1, 20);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("No request or header moved for %0d cycles.", IDLE_LIMIT);
			$display("icmp_echo_header_generator_core regression: fail");
			$finish;
		end
	end

	task automatic pace();
		int gap;
		if (steady)
			return;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				s_axis_tvalid = 1'b0;
				s_axis_tdata = {7'd0, 9'($urandom)};
				s_axis_tlast = 1'($urandom);
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
	endtask

	task automatic send_item(input logic [7:0] data_byte, input logic byte_ok,
			input logic last_flag, input logic kind);
		pace();
		s_axis_tdata = {7'd0, byte_ok, data_byte};
		s_axis_tlast = last_flag;
		s_axis_tuser = kind;
		s_axis_tvalid = 1'b1;
		do
			@(posedge clk);
		while (!s_axis_tready);
		@(negedge clk);
		if (byte_ok || last_flag)
			requests_sent++;
	endtask

	task automatic drain();
		s_axis_tvalid = 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		burst_left = 0;
	endtask

	task automatic set_identifier(input logic [15:0] value);
		drain();
		cfg_wdata = value;
		cfg_we = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
		id_writes++;
	endtask

	function automatic logic [7:0] pick_byte(input fill_t fill);
		case (fill)
			FILL_ONES: return 8'hFF;
			FILL_ZEROS: return 8'h00;
			FILL_MIXED: begin
				case ($urandom_range(0, 2))
					0: return 8'hFF;
					1: return 8'h00;
					default: return 8'($urandom);
				endcase
			end
			default: return 8'($urandom);
		endcase
	endfunction

	// A packet either ends on its final byte or on a separate marker without a byte.
	task automatic send_packet(input int nbytes, input logic marker_end, input logic kind,
			input fill_t fill);
		logic ends_here;
		for (int i = 0; i < nbytes; i++) begin
			if ($urandom_range(0, 15) == 0)
				send_item(8'($urandom), 1'b0, 1'b0, 1'($urandom));
			ends_here = (i == nbytes - 1) && !marker_end;
			send_item(pick_byte(fill), 1'b1, ends_here, ends_here ? kind : 1'($urandom));
		end
		if (nbytes == 0 || marker_end)
			send_item(8'($urandom), 1'b0, 1'b1, kind);
	endtask

	task automatic random_phase(input int target);
		int start;
		int nbytes;
		fill_t fill;
		start = requests_sent;
		while (requests_sent - start < target) begin
			nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 100)
				: $urandom_range(0, 12);
			fill = ($urandom_range(0, 1) == 0) ? FILL_RANDOM
				: fill_t'($urandom_range(0, 3));
			send_packet(nbytes, $urandom_range(0, 3) == 0, 1'($urandom), fill);
			if ($urandom_range(0, 39) == 0)
				drain();
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_item(8'h5A, 1'b0, 1'b1, KIND_REQUEST);
		send_item(8'hA5, 1'b0, 1'b1, KIND_REPLY);
		send_item(8'hFF, 1'b1, 1'b1, KIND_REPLY);

		set_identifier(16'hFFFF);
		send_item(8'hFF, 1'b1, 1'b0, KIND_REPLY);
		send_item(8'hFF, 1'b1, 1'b0, KIND_REPLY);
		send_item(8'hFF, 1'b1, 1'b1, KIND_REQUEST);
		send_item(8'h80, 1'b1, 1'b0, KIND_REQUEST);
		send_item(8'h55, 1'b0, 1'b0, KIND_REPLY);
		send_item(8'h01, 1'b1, 1'b1, KIND_REPLY);
		send_item(8'h12, 1'b1, 1'b0, KIND_REPLY);
		send_item(8'h34, 1'b1, 1'b0, KIND_REPLY);
		send_item(8'hAA, 1'b0, 1'b1, KIND_REQUEST);
		send_item(8'h00, 1'b1, 1'b0, KIND_REQUEST);
		send_item(8'h00, 1'b1, 1'b1, KIND_REQUEST);
		send_packet(4, 1'b1, KIND_REPLY, FILL_ONES);

		set_identifier(16'h0000);
		random_phase(PHASE_REQUESTS);
		set_identifier(16'($urandom));
		random_phase(PHASE_REQUESTS);

		// Empty packets at full rate, with no gaps from the bench, give one header per request unless the sink stalls.
		set_identifier(16'($urandom));
		steady = 1'b1;
		repeat (STEADY_PACKETS) send_item(8'($urandom), 1'b0, 1'b1, 1'($urandom));
		steady = 1'b0;

		set_identifier(16'h0001);
		random_phase(PHASE_REQUESTS);
		set_identifier(16'h8000);
		random_phase(PHASE_REQUESTS);
		set_identifier(16'($urandom));
		random_phase(PHASE_REQUESTS);
		drain();

		$display("Sent %0d payload and end-of-packet requests; %0d headers checked under %0d identifier values.",
			requests_sent, headers_checked, id_writes + 1);
		$display("The sequence number %s from 0xFFFF back to zero; %0d mismatches.",
			wrap_seen ? "wrapped" : "did not wrap", mismatches);
		if (mismatches == 0 && outstanding == 0)
			$display("icmp_echo_header_generator_core regression: pass");
		else
			$display("icmp_echo_header_generator_core regression: fail");
		$finish;
	end

endmodule

/* sim.f */
+incdir+hdl
hdl/ieh_pkg.sv
hdl/ieh_accum.sv
hdl/ieh_hdr_out.sv
hdl/icmp_echo_header_generator_core.sv
hdl/ieh_checker.sv
tb/sv/icmp_header_checker.sv
tb/sv/tb.sv
